### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the bit packer.
// No dependencies; checks compile out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/core/mbp_pkg.sv
// Package for the MSB-first bit packer: widths, opcodes and word types.
// No dependencies; imported by every module of the block.
package mbp_pkg;

  localparam int MAX_FIELD_WIDTH  = 16;
  localparam int VALUE_BITS       = 16;
  localparam int BYTE_BITS        = 8;
  localparam int PEND_BITS        = 7;
  localparam int CNT_BITS         = 3;
  localparam int WIDTH_FIELD_BITS = 5;
  localparam int NRES_BITS        = 2;

  localparam int WIDTH_LIMIT = (MAX_FIELD_WIDTH < VALUE_BITS) ? MAX_FIELD_WIDTH : VALUE_BITS;
  localparam int WEFF_BITS   = $clog2(WIDTH_LIMIT + 1);
  localparam int ACC_BITS    = PEND_BITS + VALUE_BITS;
  localparam int SUM_BITS    = $clog2(ACC_BITS + 1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                     opcode;
    logic [VALUE_BITS-1:0]       value;
    logic [WIDTH_FIELD_BITS-1:0] width;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 padded;
    logic                 last;
  } out_item_t;

  // Results one item produces, in output order.
  typedef struct packed {
    logic [NRES_BITS-1:0] nres;
    out_item_t            res0;
    out_item_t            res1;
  } pack_res_t;

  typedef struct packed {
    logic [PEND_BITS-1:0] bits;
    logic [CNT_BITS-1:0]  cnt;
  } pend_stat_t;

  typedef struct packed {
    logic [NRES_BITS-1:0] cnt;
    logic                 can_take;
  } buf_stat_t;

endpackage

### rtl/core/mbp_pack.sv
// Packing datapath: pending-bit state plus the append/flush logic for one word.
// Depends on mbp_pkg.
module mbp_pack
  import mbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   item,
  input  logic       fire,
  output pack_res_t  res,
  output pend_stat_t pend
);

  logic [PEND_BITS-1:0]  pend_bits_r, pend_bits_nxt;
  logic [CNT_BITS-1:0]   pend_cnt_r, pend_cnt_nxt;

  logic [WEFF_BITS-1:0]  w;
  logic [VALUE_BITS-1:0] val_mask;
  logic [VALUE_BITS-1:0] val_m;
  logic [ACC_BITS-1:0]   acc;
  logic [SUM_BITS-1:0]   sum;
  logic [CNT_BITS-1:0]   rem;
  logic [CNT_BITS:0]     rem_hi;
  logic [BYTE_BITS-1:0]  b_first, b_second, f_byte;
  logic [CNT_BITS:0]     f_shift;
  logic [PEND_BITS-1:0]  new_bits;
  logic [BYTE_BITS:0]    f_wide;

  always_comb begin
    // Saturate oversize widths to the field limit.
    if (item.width > WIDTH_FIELD_BITS'(WIDTH_LIMIT)) begin
      w = WEFF_BITS'(WIDTH_LIMIT);
    end else begin
      w = WEFF_BITS'(item.width);
    end
    val_mask = ~({VALUE_BITS{1'b1}} << w);
    val_m    = item.value & val_mask;
    acc      = (ACC_BITS'(pend_bits_r) << w) | ACC_BITS'(val_m);
    sum      = SUM_BITS'(pend_cnt_r) + SUM_BITS'(w);
    if (sum >= SUM_BITS'(2 * BYTE_BITS)) begin
      rem = CNT_BITS'(sum - SUM_BITS'(2 * BYTE_BITS));
    end else if (sum >= SUM_BITS'(BYTE_BITS)) begin
      rem = CNT_BITS'(sum - SUM_BITS'(BYTE_BITS));
    end else begin
      rem = CNT_BITS'(sum);
    end
    rem_hi   = {1'b0, rem} + (CNT_BITS + 1)'(BYTE_BITS);
    b_second = BYTE_BITS'(acc >> rem);
    b_first  = BYTE_BITS'(acc >> rem_hi);
    new_bits = PEND_BITS'(acc) & ~({PEND_BITS{1'b1}} << rem);

    // Left-align the partial byte for a flush.
    f_shift  = (CNT_BITS + 1)'(BYTE_BITS) - {1'b0, pend_cnt_r};
    f_wide   = (BYTE_BITS + 1)'(pend_bits_r) << f_shift;
    f_byte   = f_wide[BYTE_BITS-1:0];
  end

  always_comb begin
    res           = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    unique case (item.opcode)
      OP_FLUSH: begin
        if (pend_cnt_r != '0) begin
          res.nres = NRES_BITS'(1);
          res.res0 = '{out_byte: f_byte, padded: 1'b1, last: 1'b1};
        end
        if (fire) begin
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
        end
      end
      default: begin
        if (sum >= SUM_BITS'(2 * BYTE_BITS)) begin
          res.nres = NRES_BITS'(2);
          res.res0 = '{out_byte: b_first, padded: 1'b0, last: 1'b0};
          res.res1 = '{out_byte: b_second, padded: 1'b0, last: 1'b1};
        end else if (sum >= SUM_BITS'(BYTE_BITS)) begin
          res.nres = NRES_BITS'(1);
          res.res0 = '{out_byte: b_second, padded: 1'b0, last: 1'b1};
        end
        if (fire) begin
          pend_bits_nxt = new_bits;
          pend_cnt_nxt  = rem;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  assign pend.bits = pend_bits_r;
  assign pend.cnt  = pend_cnt_r;

endmodule

### rtl/core/mbp_out_buf.sv
// Two-entry result buffer: loads all bytes of one item, drains one per cycle while out_ready is high.
// Depends on mbp_pkg.
module mbp_out_buf
  import mbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  pack_res_t res,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  output buf_stat_t stat
);

  logic [NRES_BITS-1:0] cnt_r, cnt_nxt;
  out_item_t            e0_r, e0_nxt;
  out_item_t            e1_r, e1_nxt;
  logic                 pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = e0_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (load) begin
      cnt_nxt = res.nres;
      e0_nxt  = res.res0;
      e1_nxt  = res.res1;
    end else if (pop) begin
      // advance the second byte to the front
      cnt_nxt = cnt_r - NRES_BITS'(1);
      e0_nxt  = e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign stat.cnt      = cnt_r;
  assign stat.can_take = (cnt_r == '0) || ((cnt_r == NRES_BITS'(1)) && out_ready);

endmodule

### rtl/core/msb_first_bit_packer_unit.sv
// MSB-first bit packer, top level. Depends on mbp_pkg, mbp_pack, mbp_out_buf.
// Path: an accepted word is registered at the input, then its bytes are loaded into the
// output buffer. Throughput: one word per cycle when it yields at most one byte and out_ready
// is high; a word that completes two bytes waits until the one-byte-per-cycle output drains.
// Reset (rst_n, synchronous): clears pending bits, input and output valids.
`include "assert_macros.svh"

module msb_first_bit_packer_unit
  import mbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       in_vld_r, in_vld_nxt;
  in_item_t   in_item_r;
  logic       fire;
  logic       load;
  pack_res_t  res;
  pend_stat_t pend;
  buf_stat_t  bstat;

  // An item with no bytes never waits on the output buffer.
  assign fire     = in_vld_r && ((res.nres == '0) || bstat.can_take);
  assign load     = fire && (res.nres != '0);
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  mbp_pack u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_item_r),
    .fire  (fire),
    .res   (res),
    .pend  (pend)
  );

  mbp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (bstat)
  );

  `ASSERT_CLK(a_pend_clean, clk, rst_n, ((pend.bits >> pend.cnt) == '0))
  `ASSERT_CLK(a_flush_clears, clk, rst_n, fire && in_item_r.opcode == OP_FLUSH |=> pend.cnt == '0)
  `ASSERT_NEVER(a_buf_overfill, clk, rst_n, (bstat.cnt > NRES_BITS'(2)))
  `ASSERT_CLK(a_pair_order, clk, rst_n, (bstat.cnt == NRES_BITS'(2)) |-> !out_data.last)

endmodule
